// ===== rtl/core/dtnp_pkg.sv =====
`timescale 1ns / 1ps

package dtnp_pkg;

	localparam int MANT_DIGITS = 18;
	localparam int EXP_MAX = 999;

	localparam int MANT_W = 60;
	localparam int FRAC_W = 10;
	localparam int EXP_W = $clog2(EXP_MAX + 1);
	localparam int DEXP_W = 12;
	localparam int ECALC_W = ((EXP_W > FRAC_W) ? EXP_W : FRAC_W) + 2;
	localparam int DEXP_HI = 2047;
	localparam int DEXP_LO = -2048;

	localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

	localparam logic [2:0] PH_SPACE = 3'd0;
	localparam logic [2:0] PH_INT = 3'd1;
	localparam logic [2:0] PH_FRAC = 3'd2;
	localparam logic [2:0] PH_ESIGN = 3'd3;
	localparam logic [2:0] PH_EDIG = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_E_LO = 8'h65;
	localparam logic [7:0] CH_E_UP = 8'h45;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;

	function automatic logic [MANT_W-1:0] mant_limit_f();
		logic [63:0] p;
		logic [63:0] wmax;
		p = 64'd1;
		wmax = {{(64 - MANT_W){1'b0}}, {MANT_W{1'b1}}};
		for (int k = 0; k < MANT_DIGITS && k < 19; k++) begin
			p = p * 64'd10;
		end
		p = p - 64'd1;
		if (p > wmax) begin
			p = wmax;
		end
		return p[MANT_W-1:0];
	endfunction

	localparam logic [MANT_W-1:0] MANT_LIMIT = mant_limit_f();
	localparam logic [EXP_W-1:0] EXP_LIMIT = EXP_W'(EXP_MAX);

	typedef struct packed {
		logic [2:0] phase;
		logic mant_neg;
		logic [MANT_W-1:0] mant;
		logic [FRAC_W-1:0] frac;
		logic [EXP_W-1:0] expo;
		logic exp_neg;
		logic sat;
	} parse_state_t;

	localparam parse_state_t STATE_RST = '{
		phase: PH_SPACE, mant_neg: 1'b0, mant: '0, frac: '0,
		expo: '0, exp_neg: 1'b0, sat: 1'b0
	};

endpackage

// ===== rtl/core/dtnp_step.sv =====
`timescale 1ns / 1ps

module dtnp_step import dtnp_pkg::*; (
	input parse_state_t cur,
	input logic [7:0] char_code,
	output parse_state_t nxt
);

	logic is_digit;
	logic is_space;
	logic is_sign;
	logic [3:0] digit;
	logic [MANT_W+3:0] mant_sum;
	logic mant_over;
	logic [EXP_W+3:0] exp_sum;
	logic exp_over;

	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_space = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
	assign is_sign = (char_code == CH_MINUS) || (char_code == CH_PLUS);
	assign digit = 4'(char_code - CH_ZERO);

	// x*10 + d as two shifts and two adds; saturate when past the limit
	assign mant_sum = ({4'b0, cur.mant} << 3) + ({4'b0, cur.mant} << 1)
		+ (MANT_W + 4)'(digit);
	assign mant_over = mant_sum > (MANT_W + 4)'(MANT_LIMIT);
	assign exp_sum = ({4'b0, cur.expo} << 3) + ({4'b0, cur.expo} << 1)
		+ (EXP_W + 4)'(digit);
	assign exp_over = exp_sum > (EXP_W + 4)'(EXP_LIMIT);

	always_comb begin
		logic [2:0] ph;
		logic fin;
		nxt = cur;
		ph = cur.phase;
		fin = (cur.phase == PH_DONE);
		if (!fin && ph == PH_SPACE) begin
			if (is_space) begin
				fin = 1'b1;
			end else begin
				ph = PH_INT;
				if (is_sign) begin
					nxt.mant_neg = (char_code == CH_MINUS);
					nxt.phase = PH_INT;
					fin = 1'b1;
				end
			end
		end
		if (!fin && ph == PH_INT) begin
			if (is_digit) begin
				nxt.mant = mant_over ? MANT_LIMIT : mant_sum[MANT_W-1:0];
				nxt.sat = cur.sat | mant_over;
				nxt.phase = PH_INT;
				fin = 1'b1;
			end else if (char_code == CH_DOT) begin
				nxt.phase = PH_FRAC;
				fin = 1'b1;
			end else begin
				ph = PH_FRAC;
			end
		end
		if (!fin && ph == PH_FRAC) begin
			if (is_digit) begin
				nxt.mant = mant_over ? MANT_LIMIT : mant_sum[MANT_W-1:0];
				nxt.frac = (cur.frac == FRAC_MAX) ? cur.frac : cur.frac + 1'b1;
				nxt.sat = cur.sat | mant_over | (cur.frac == FRAC_MAX);
				nxt.phase = PH_FRAC;
				fin = 1'b1;
			end else if (char_code == CH_E_LO || char_code == CH_E_UP) begin
				nxt.phase = PH_ESIGN;
				fin = 1'b1;
			end else begin
				ph = PH_ESIGN;
			end
		end
		if (!fin && ph == PH_ESIGN) begin
			if (is_sign) begin
				nxt.exp_neg = (char_code == CH_MINUS);
				nxt.phase = PH_EDIG;
				fin = 1'b1;
			end
		end
		if (!fin) begin
			if (is_digit) begin
				nxt.expo = exp_over ? EXP_LIMIT : exp_sum[EXP_W-1:0];
				nxt.sat = cur.sat | exp_over;
				nxt.phase = PH_EDIG;
			end else begin
				nxt.phase = PH_DONE;
			end
		end
	end

endmodule

// ===== rtl/core/dtnp_result.sv =====
`timescale 1ns / 1ps

module dtnp_result import dtnp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input parse_state_t fin,
	input logic out_ready,
	output logic out_valid,
	output logic is_negative,
	output logic [MANT_W-1:0] mantissa,
	output logic signed [DEXP_W-1:0] dec_exponent,
	output logic overflow
);

	logic [ECALC_W-1:0] exp_ext;
	logic [ECALC_W-1:0] frac_ext;
	logic signed [ECALC_W-1:0] e_raw;
	logic e_hi;
	logic e_lo;
	logic signed [DEXP_W-1:0] e_clamp;
	logic valid_q;
	logic neg_q;
	logic [MANT_W-1:0] mant_q;
	logic signed [DEXP_W-1:0] dexp_q;
	logic ovf_q;

	assign exp_ext = ECALC_W'(fin.expo);
	assign frac_ext = ECALC_W'(fin.frac);
	assign e_raw = fin.exp_neg ? (-$signed(exp_ext) - $signed(frac_ext))
		: ($signed(exp_ext) - $signed(frac_ext));
	assign e_hi = e_raw > $signed(ECALC_W'(DEXP_HI));
	assign e_lo = e_raw < $signed(ECALC_W'(DEXP_LO));

	always_comb begin
		priority if (e_hi) begin
			e_clamp = DEXP_W'(DEXP_HI);
		end else if (e_lo) begin
			e_clamp = DEXP_W'(DEXP_LO);
		end else begin
			e_clamp = e_raw[DEXP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= fin.mant_neg;
			mant_q <= fin.mant;
			dexp_q <= e_clamp;
			ovf_q <= fin.sat | e_hi | e_lo;
		end
	end

	assign out_valid = valid_q;
	assign is_negative = neg_q;
	assign mantissa = mant_q;
	assign dec_exponent = dexp_q;
	assign overflow = ovf_q;

endmodule

// ===== rtl/core/decimal_text_number_parser.sv =====
`timescale 1ns / 1ps

// Decimal text number parser.
// Input channel (in_valid/in_ready): one character beat per cycle while in_ready is high,
// char_code plus line_end on the last character of a line. Output channel (out_valid/out_ready):
// one result beat per line: is_negative, mantissa, dec_exponent, overflow, so that
// value = (-1)^is_negative * mantissa * 10^dec_exponent.
// Throughput: one character per cycle while in_ready is high. Each beat lands in an
// input register and is parsed by the per-character step (multiply-by-ten-and-add
// on the mantissa and exponent, plus phase logic), which updates the parse state as
// the beat leaves the input register. The beat carrying line_end leaves it only
// when the output register is free, and then loads the result into the output
// register and raises out_valid.
// Reset clears the parse state and the valid flags of the input and output
// registers; the block is ready right after reset.
// When the receiver stalls, characters that do not end a line keep flowing; a
// line-end beat waits in the input register until the output register frees, and
// in_ready stays low while it waits.
module decimal_text_number_parser import dtnp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] char_code,
	input logic line_end,
	output logic out_valid,
	input logic out_ready,
	output logic is_negative,
	output logic [MANT_W-1:0] mantissa,
	output logic signed [DEXP_W-1:0] dec_exponent,
	output logic overflow
);

	logic valid_s1;
	logic [7:0] char_s1;
	logic end_s1;
	logic adv;
	parse_state_t state_q;
	parse_state_t state_nxt;

	assign adv = valid_s1 && (!end_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			end_s1 <= line_end;
		end
	end

	dtnp_step u_step (
		.cur(state_q),
		.char_code(char_s1),
		.nxt(state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (adv) begin
			state_q <= end_s1 ? STATE_RST : state_nxt;
		end
	end

	dtnp_result u_result (
		.clk(clk),
		.arst_n(arst_n),
		.load(adv && end_s1),
		.fin(state_nxt),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.is_negative(is_negative),
		.mantissa(mantissa),
		.dec_exponent(dec_exponent),
		.overflow(overflow)
	);

	a_mant_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mant <= MANT_LIMIT)
		else $error("mantissa accumulator above limit");

	a_exp_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.expo <= EXP_LIMIT)
		else $error("exponent accumulator above limit");

	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && end_s1) |=> (state_q.phase == PH_SPACE && state_q.mant == '0
			&& state_q.frac == '0 && !state_q.sat && out_valid))
		else $error("state not cleared or result missing after line end");

endmodule
